// File: rtl/pospi_pkg.sv
`default_nettype none
package pospi_pkg;

  // Field and register widths
  localparam int DATA_W        = 32;
  localparam int KP_W          = 24;
  localparam int KI_W          = 32;
  localparam int LIM_W         = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int KP_FRAC       = 16;
  localparam int KI_FRAC       = 28;

  // Shared multiplier: signed operands, one bit wider than the data
  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int WIDE_W = 2 * DATA_W;

  // Shift-subtract unit
  localparam int SD_ITERS = DATA_W;
  localparam int SD_CNT_W = $clog2(SD_ITERS);
  localparam int SD_REM_W = DATA_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZ_KP,
    REG_HORIZ_KI_DT,
    REG_HORIZ_INT_LIMIT,
    REG_VERT_KP,
    REG_VERT_KI_DT,
    REG_VERT_INT_LIMIT,
    REG_HORIZ_SPEED_MAX,
    REG_VERT_SPEED_MAX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AX_NORTH,
    AX_EAST,
    AX_DOWN
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KI,
    ST_KP,
    ST_CMD,
    ST_SQN,
    ST_SQE,
    ST_SQM,
    ST_CMP,
    ST_SQRT,
    ST_MULN,
    ST_STN,
    ST_DIVN,
    ST_MULE,
    ST_STE,
    ST_DIVE,
    ST_FIN
  } pospi_state_t;

  typedef enum logic {
    SD_SQRT,
    SD_DIV
  } sd_mode_t;

  typedef struct packed {
    logic     start;
    sd_mode_t mode;
  } sd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sd_sts_t;

endpackage
`default_nettype wire

// File: rtl/pospi_mul.sv
`default_nettype none
module pospi_mul
  import pospi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output      logic signed [PROD_W-1:0] prod
);

  // One registered signed multiply; result is valid the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// File: rtl/pospi_sqdiv.sv
`default_nettype none
module pospi_sqdiv
  import pospi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sd_ctl_t           ctl,
  input  wire logic [WIDE_W-1:0] operand,
  input  wire logic [DATA_W-1:0] divisor,
  output      sd_sts_t           sts,
  output      logic [DATA_W-1:0] result
);

  sd_mode_t            mode;
  logic [SD_CNT_W-1:0] cnt;
  logic [WIDE_W-1:0]   opnd;
  logic [SD_REM_W-1:0] rem;
  logic [DATA_W-1:0]   dvsr;

  logic [SD_REM_W-1:0] rem_sh;
  logic [SD_REM_W-1:0] trial;
  logic [SD_REM_W:0]   diff;
  logic                ge;

  // One root bit or one quotient bit per cycle through a single subtractor
  always_comb begin
    unique case (mode)
      SD_SQRT: begin
        rem_sh = {rem[SD_REM_W-3:0], opnd[WIDE_W-1 -: 2]};
        trial  = SD_REM_W'({result, 2'b01});
      end
      SD_DIV: begin
        rem_sh = {rem[SD_REM_W-2:0], opnd[WIDE_W-1]};
        trial  = SD_REM_W'(dvsr);
      end
    endcase
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = !diff[SD_REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sts  <= '0;
      cnt  <= '0;
      mode <= SD_SQRT;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        sts.busy <= 1'b1;
        cnt      <= '0;
        mode     <= ctl.mode;
      end else if (sts.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SD_CNT_W'(SD_ITERS - 1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      result <= '0;
      dvsr   <= divisor;
      if (ctl.mode == SD_SQRT) begin
        rem  <= '0;
        opnd <= operand;
      end else begin
        // High half is already below the divisor, so 32 steps cover the quotient
        rem  <= SD_REM_W'(operand[WIDE_W-1:DATA_W]);
        opnd <= {operand[DATA_W-1:0], {DATA_W{1'b0}}};
      end
    end else if (sts.busy) begin
      rem    <= ge ? diff[SD_REM_W-1:0] : rem_sh;
      result <= {result[DATA_W-2:0], ge};
      opnd   <= (mode == SD_SQRT) ? {opnd[WIDE_W-3:0], 2'b00} : {opnd[WIDE_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// File: rtl/position_pi_velocity_command.sv
`default_nettype none
// Three-axis position PI controller with a horizontal speed vector limit.
// Each input transfer carries target and measured positions (north, east, down) and a
// clear flag; each one yields exactly one output transfer with the three velocity
// commands and a flag that marks a scaled horizontal vector. Per axis the error is
// target minus position (saturated), the integrator adds error*Ki_dt (Q4.28) and is
// clamped to +-limit, and the command is error*Kp (Q8.16) plus the integrator. When
// the horizontal vector exceeds horiz_speed_max both horizontal commands are scaled
// by max/|v| (|v| = floor square root); the down command is clamped to
// +-vert_speed_max. A set clear flag zeroes the integrators and returns all zeros.
// Timing: one item at a time. A new input transfer is accepted only after the previous
// item has been loaded into the output register, and that load waits while the register
// is still full. A scaled item takes longest and a clear the least. The scaled case
// runs the shared shift-subtract unit for the square root and then for each of the two
// divisions. All products go through one registered 33x33 multiplier.
// A finished result waits in the output register while the next item is accepted.
// Configuration writes take effect at once and belong between items.
module position_pi_velocity_command
  import pospi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_tvalid,
  output      logic                   s_tready,
  // target_north, target_east, target_down, pos_north, pos_east, pos_down
  input  wire logic [6*DATA_W-1:0]    s_tdata,
  // clear
  input  wire logic                   s_tuser,
  // output stream
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  // vel_north, vel_east, vel_down
  output      logic [3*DATA_W-1:0]    m_tdata,
  // horiz_limited
  output      logic                   m_tuser,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [KP_W-1:0]  horiz_kp, vert_kp;
  logic [KI_W-1:0]  horiz_ki_dt, vert_ki_dt;
  logic [LIM_W-1:0] horiz_int_limit, vert_int_limit;
  logic [LIM_W-1:0] horiz_speed_max, vert_speed_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_kp        <= KP_W'(1) << KP_FRAC;
      horiz_ki_dt     <= '0;
      horiz_int_limit <= LIM_W'(1) << FRAC_BITS;
      vert_kp         <= KP_W'(1) << KP_FRAC;
      vert_ki_dt      <= '0;
      vert_int_limit  <= LIM_W'(1) << FRAC_BITS;
      horiz_speed_max <= LIM_W'(10) << FRAC_BITS;
      vert_speed_max  <= LIM_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HORIZ_KP:        horiz_kp        <= cfg_data[KP_W-1:0];
        REG_HORIZ_KI_DT:     horiz_ki_dt     <= cfg_data[KI_W-1:0];
        REG_HORIZ_INT_LIMIT: horiz_int_limit <= cfg_data[LIM_W-1:0];
        REG_VERT_KP:         vert_kp         <= cfg_data[KP_W-1:0];
        REG_VERT_KI_DT:      vert_ki_dt      <= cfg_data[KI_W-1:0];
        REG_VERT_INT_LIMIT:  vert_int_limit  <= cfg_data[LIM_W-1:0];
        REG_HORIZ_SPEED_MAX: horiz_speed_max <= cfg_data[LIM_W-1:0];
        REG_VERT_SPEED_MAX:  vert_speed_max  <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

  // Sequencer and working registers
  pospi_state_t state, state_next;
  axis_t        ax;

  logic signed [DATA_W-1:0] err_q   [3];
  logic signed [DATA_W-1:0] integ_q [3];
  logic signed [DATA_W-1:0] cmd_q   [3];
  logic [WIDE_W-1:0]        sum_q;
  logic [DATA_W-1:0]        mag_q, qn_q, qe_q;
  logic                     limited;

  // Shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  sd_ctl_t                  sd_ctl;
  sd_sts_t                  sd_sts;
  logic [WIDE_W-1:0]        sd_operand;
  logic [DATA_W-1:0]        sd_result;

  pospi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pospi_sqdiv u_sqdiv (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sd_ctl),
    .operand (sd_operand),
    .divisor (mag_q),
    .sts     (sd_sts),
    .result  (sd_result)
  );

  // Input errors, saturated to the signed data range
  logic signed [DATA_W-1:0] err_in [3];
  always_comb begin
    logic signed [DATA_W:0] d;
    for (int i = 0; i < 3; i++) begin
      d = $signed({s_tdata[i*DATA_W + DATA_W-1], s_tdata[i*DATA_W +: DATA_W]})
        - $signed({s_tdata[(i+3)*DATA_W + DATA_W-1], s_tdata[(i+3)*DATA_W +: DATA_W]});
      if (d[DATA_W] != d[DATA_W-1]) begin
        err_in[i] = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        err_in[i] = d[DATA_W-1:0];
      end
    end
  end

  // Per-axis gain selection: down axis uses the vertical set
  logic [KP_W-1:0]  kp_sel;
  logic [KI_W-1:0]  ki_sel;
  logic [LIM_W-1:0] lim_sel;
  always_comb begin
    if (ax == AX_DOWN) begin
      kp_sel  = vert_kp;
      ki_sel  = vert_ki_dt;
      lim_sel = vert_int_limit;
    end else begin
      kp_sel  = horiz_kp;
      ki_sel  = horiz_ki_dt;
      lim_sel = horiz_int_limit;
    end
  end

  // Magnitudes of the horizontal commands
  logic [DATA_W-1:0] an, ae;
  assign an = cmd_q[AX_NORTH][DATA_W-1] ? DATA_W'(-cmd_q[AX_NORTH]) : cmd_q[AX_NORTH];
  assign ae = cmd_q[AX_EAST][DATA_W-1]  ? DATA_W'(-cmd_q[AX_EAST])  : cmd_q[AX_EAST];

  // Integrator update: floor(err*ki/2^28) added, clamped to +-limit
  localparam int INC_W = WIDE_W + 1 - KI_FRAC;
  logic signed [INC_W-1:0]   inc;
  logic signed [INC_W:0]     integ_sum, lim_s;
  logic signed [DATA_W-1:0]  integ_new;
  always_comb begin
    inc       = prod[WIDE_W:KI_FRAC];
    integ_sum = (INC_W+1)'(integ_q[ax]) + (INC_W+1)'(inc);
    lim_s     = $signed((INC_W+1)'(lim_sel));
    if (integ_sum > lim_s) begin
      integ_new = DATA_W'(lim_s);
    end else if (integ_sum < -lim_s) begin
      integ_new = DATA_W'(-lim_s);
    end else begin
      integ_new = DATA_W'(integ_sum);
    end
  end

  // Command: floor(err*kp/2^16) plus the updated integrator, saturated
  localparam int KPT_W = DATA_W + KP_W + 1 - KP_FRAC + 1;
  logic signed [KPT_W-1:0]  kp_term;
  logic signed [KPT_W:0]    cmd_sum;
  logic signed [DATA_W-1:0] cmd_new;
  always_comb begin
    kp_term = prod[KPT_W-1+KP_FRAC:KP_FRAC];
    cmd_sum = (KPT_W+1)'(kp_term) + (KPT_W+1)'(integ_q[ax]);
    if (cmd_sum > (KPT_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      cmd_new = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (cmd_sum < (KPT_W+1)'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
      cmd_new = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      cmd_new = DATA_W'(cmd_sum);
    end
  end

  logic over;
  logic out_free;
  assign over     = sum_q > prod[WIDE_W-1:0];
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = s_tuser ? ST_FIN : ST_KI;
      ST_KI:   state_next = ST_KP;
      ST_KP:   state_next = ST_CMD;
      ST_CMD:  state_next = (ax == AX_DOWN) ? ST_SQN : ST_KI;
      ST_SQN:  state_next = ST_SQE;
      ST_SQE:  state_next = ST_SQM;
      ST_SQM:  state_next = ST_CMP;
      ST_CMP:  state_next = over ? ST_SQRT : ST_FIN;
      ST_SQRT: if (sd_sts.done) state_next = ST_MULN;
      ST_MULN: state_next = ST_STN;
      ST_STN:  state_next = ST_DIVN;
      ST_DIVN: if (sd_sts.done) state_next = ST_MULE;
      ST_MULE: state_next = ST_STE;
      ST_STE:  state_next = ST_DIVE;
      ST_DIVE: if (sd_sts.done) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands and unit control
  always_comb begin
    s_tready      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sd_ctl.start  = 1'b0;
    sd_ctl.mode   = SD_DIV;
    sd_operand    = prod[WIDE_W-1:0];
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_KI: begin
        mul_a = MUL_W'(err_q[ax]);
        mul_b = $signed({1'b0, ki_sel});
      end
      ST_KP: begin
        mul_a = MUL_W'(err_q[ax]);
        mul_b = $signed(MUL_W'(kp_sel));
      end
      ST_SQN: begin
        mul_a = $signed({1'b0, an});
        mul_b = $signed({1'b0, an});
      end
      ST_SQE: begin
        mul_a = $signed({1'b0, ae});
        mul_b = $signed({1'b0, ae});
      end
      ST_SQM: begin
        mul_a = $signed(MUL_W'(horiz_speed_max));
        mul_b = $signed(MUL_W'(horiz_speed_max));
      end
      ST_CMP: begin
        // Exact compare of |v|^2 against max^2; root only when over
        sd_ctl.start = over;
        sd_ctl.mode  = SD_SQRT;
        sd_operand   = sum_q;
      end
      ST_MULN: begin
        mul_a = $signed({1'b0, an});
        mul_b = $signed(MUL_W'(horiz_speed_max));
      end
      ST_MULE: begin
        mul_a = $signed({1'b0, ae});
        mul_b = $signed(MUL_W'(horiz_speed_max));
      end
      ST_STN, ST_STE: sd_ctl.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ax      <= AX_NORTH;
      integ_q <= '{default: '0};
      limited <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          ax <= AX_NORTH;
          if (s_tvalid) begin
            limited <= 1'b0;
            if (s_tuser) begin
              integ_q <= '{default: '0};
              cmd_q   <= '{default: '0};
            end else begin
              err_q <= err_in;
            end
          end
        end
        ST_KP:  integ_q[ax] <= integ_new;
        ST_CMD: begin
          cmd_q[ax] <= cmd_new;
          if (ax != AX_DOWN) ax <= axis_t'(ax + 1'b1);
        end
        ST_SQE:  sum_q <= prod[WIDE_W-1:0];
        ST_SQM:  sum_q <= sum_q + prod[WIDE_W-1:0];
        ST_CMP:  limited <= over;
        ST_SQRT: if (sd_sts.done) mag_q <= sd_result;
        ST_DIVN: if (sd_sts.done) qn_q <= sd_result;
        ST_DIVE: if (sd_sts.done) qe_q <= sd_result;
        default: ;
      endcase
    end
  end

  // Final assembly: apply signs to the scaled commands and clamp the down axis
  logic signed [DATA_W-1:0] vel_n, vel_e, vel_d;
  logic signed [DATA_W-1:0] vmax_s;
  always_comb begin
    vmax_s = $signed(DATA_W'(vert_speed_max));
    if (limited) begin
      vel_n = cmd_q[AX_NORTH][DATA_W-1] ? -$signed(qn_q) : $signed(qn_q);
      vel_e = cmd_q[AX_EAST][DATA_W-1]  ? -$signed(qe_q) : $signed(qe_q);
    end else begin
      vel_n = cmd_q[AX_NORTH];
      vel_e = cmd_q[AX_EAST];
    end
    if (cmd_q[AX_DOWN] > vmax_s) begin
      vel_d = vmax_s;
    end else if (cmd_q[AX_DOWN] < -vmax_s) begin
      vel_d = -vmax_s;
    end else begin
      vel_d = cmd_q[AX_DOWN];
    end
  end

  // Output register: hold the result until the transfer completes
  logic out_load;
  assign out_load = (state == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {vel_d, vel_e, vel_n};
      m_tuser <= limited;
    end
  end

`ifndef SYNTHESIS
  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    sd_sts.busy |-> state != ST_IDLE)
    else $error("shift-subtract unit busy while accepting input");

  a_clear_zeroes_integ: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=>
      (integ_q[AX_NORTH] == '0 && integ_q[AX_EAST] == '0 && integ_q[AX_DOWN] == '0))
    else $error("clear did not zero the integrators");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("output register loaded outside the final step");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sd_sts.done |-> (state == ST_SQRT || state == ST_DIVN || state == ST_DIVE))
    else $error("unit finished outside a wait state");
`endif

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pospi_pkg::*;

  localparam int ONE           = 1 << FRAC_BITS_DEF;  // 1.0 in Q16.16
  localparam int SETTLE_CYCLES = 140;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PRINT_LIMIT   = 50;

  // One position sample and the velocity command that it yields
  typedef struct packed {
    logic                     clear;
    logic signed [DATA_W-1:0] target_north;
    logic signed [DATA_W-1:0] target_east;
    logic signed [DATA_W-1:0] target_down;
    logic signed [DATA_W-1:0] pos_north;
    logic signed [DATA_W-1:0] pos_east;
    logic signed [DATA_W-1:0] pos_down;
  } pos_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vel_north;
    logic signed [DATA_W-1:0] vel_east;
    logic signed [DATA_W-1:0] vel_down;
    logic                     limited;
  } vel_cmd_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // target_north, target_east, target_down, pos_north, pos_east, pos_down
  logic [6*DATA_W-1:0]   s_tdata;
  // clear
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // vel_north, vel_east, vel_down
  logic [3*DATA_W-1:0]   m_tdata;
  // horiz_limited
  logic                  m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0]     cfg_data;

  position_pi_velocity_command dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Samples waiting for the driver, and commands waiting for the output side
  pos_item_t pending_items[$];
  vel_cmd_t  expected_cmds[$];
  pos_item_t in_flight;

  // Mirror of the controller: gains, limits and the three integrators
  logic [KP_W-1:0]          horiz_kp_r, vert_kp_r;
  logic [KI_W-1:0]          horiz_ki_r, vert_ki_r;
  logic [LIM_W-1:0]         horiz_lim_r, vert_lim_r;
  logic [LIM_W-1:0]         horiz_speed_r, vert_speed_r;
  logic signed [DATA_W-1:0] axis_integ [3];

  int send_idle_pct;
  int recv_idle_pct;
  int n_errors;
  int n_results;
  int n_limited;
  int n_clears;
  int n_settings;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate to the signed 32-bit range
  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Floor square root, one result bit per pass from the top
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Advance the integrators by one sample and form the velocity command
  function automatic vel_cmd_t predict_command(pos_item_t it);
    vel_cmd_t                 res;
    logic signed [DATA_W-1:0] tgt [3];
    logic signed [DATA_W-1:0] pos [3];
    longint                   err [3];
    longint                   cmd [3];
    longint unsigned          mag_abs [2];
    longint                   kp, ki, lim, acc, vmax;
    longint unsigned          mag_sq, cap, mag, q;
    res = '0;
    if (it.clear) begin
      for (int a = 0; a < 3; a++) axis_integ[a] = '0;
      return res;
    end
    tgt[0] = it.target_north;
    tgt[1] = it.target_east;
    tgt[2] = it.target_down;
    pos[0] = it.pos_north;
    pos[1] = it.pos_east;
    pos[2] = it.pos_down;
    for (int a = 0; a < 3; a++) begin
      if (a == int'(AX_DOWN)) begin
        kp  = vert_kp_r;
        ki  = vert_ki_r;
        lim = vert_lim_r;
      end else begin
        kp  = horiz_kp_r;
        ki  = horiz_ki_r;
        lim = horiz_lim_r;
      end
      err[a] = sat32(longint'(tgt[a]) - longint'(pos[a]));
      acc = longint'(axis_integ[a]) + ((err[a] * ki) >>> KI_FRAC);
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      axis_integ[a] = acc[DATA_W-1:0];
      cmd[a] = sat32(((err[a] * kp) >>> KP_FRAC) + acc);
    end
    // Horizontal vector limit: exact test on the squares, then scale onto the cap
    for (int a = 0; a < 2; a++) mag_abs[a] = (cmd[a] < 0) ? -cmd[a] : cmd[a];
    cap    = horiz_speed_r;
    mag_sq = mag_abs[0] * mag_abs[0] + mag_abs[1] * mag_abs[1];
    if (mag_sq > cap * cap) begin
      mag = floor_sqrt(mag_sq);
      for (int a = 0; a < 2; a++) begin
        q = (mag_abs[a] * cap) / mag;
        cmd[a] = (cmd[a] < 0) ? -longint'(q) : longint'(q);
      end
      res.limited = 1'b1;
    end
    vmax = vert_speed_r;
    if (cmd[2] > vmax) cmd[2] = vmax;
    else if (cmd[2] < -vmax) cmd[2] = -vmax;
    res.vel_north = cmd[0][DATA_W-1:0];
    res.vel_east  = cmd[1][DATA_W-1:0];
    res.vel_down  = cmd[2][DATA_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (n_errors < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic push_item(logic clear, logic signed [DATA_W-1:0] tn, logic signed [DATA_W-1:0] te,
                           logic signed [DATA_W-1:0] td, logic signed [DATA_W-1:0] pn,
                           logic signed [DATA_W-1:0] pe, logic signed [DATA_W-1:0] pd);
    pos_item_t it;
    it.clear        = clear;
    it.target_north = tn;
    it.target_east  = te;
    it.target_down  = td;
    it.pos_north    = pn;
    it.pos_east     = pe;
    it.pos_down     = pd;
    pending_items.push_back(it);
  endtask

  // Hold until every sample is sent and every command has come back, then let the
  // block settle; sample at the falling edge so the rising-edge updates have landed
  task automatic wait_idle();
    while (pending_items.size() != 0 || s_tvalid || expected_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; bits above the register width carry junk, which the block drops
  task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] keep;
    logic [DATA_W-1:0] word;
    case (idx)
      REG_HORIZ_KP, REG_VERT_KP:         keep = 32'h00FF_FFFF;
      REG_HORIZ_KI_DT, REG_VERT_KI_DT:   keep = 32'hFFFF_FFFF;
      default:                           keep = 32'h7FFF_FFFF;
    endcase
    word = (val & keep) | ($urandom & ~keep);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    case (idx)
      REG_HORIZ_KP:        horiz_kp_r    = word[KP_W-1:0];
      REG_HORIZ_KI_DT:     horiz_ki_r    = word[KI_W-1:0];
      REG_HORIZ_INT_LIMIT: horiz_lim_r   = word[LIM_W-1:0];
      REG_VERT_KP:         vert_kp_r     = word[KP_W-1:0];
      REG_VERT_KI_DT:      vert_ki_r     = word[KI_W-1:0];
      REG_VERT_INT_LIMIT:  vert_lim_r    = word[LIM_W-1:0];
      REG_HORIZ_SPEED_MAX: horiz_speed_r = word[LIM_W-1:0];
      default:             vert_speed_r  = word[LIM_W-1:0];
    endcase
  endtask

  task automatic apply_setting(logic [31:0] kp_h, logic [31:0] ki_h, logic [31:0] lim_h,
                               logic [31:0] kp_v, logic [31:0] ki_v, logic [31:0] lim_v,
                               logic [31:0] spd_h, logic [31:0] spd_v);
    wait_idle();
    write_reg(REG_HORIZ_KP, kp_h);
    write_reg(REG_HORIZ_KI_DT, ki_h);
    write_reg(REG_HORIZ_INT_LIMIT, lim_h);
    write_reg(REG_VERT_KP, kp_v);
    write_reg(REG_VERT_KI_DT, ki_v);
    write_reg(REG_VERT_INT_LIMIT, lim_v);
    write_reg(REG_HORIZ_SPEED_MAX, spd_h);
    write_reg(REG_VERT_SPEED_MAX, spd_v);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_offset(int unsigned spread);
    return int'($urandom_range(0, 2 * spread)) - int'(spread);
  endfunction

  // Mostly plausible tracking samples (target near the measured position), the rest
  // full-range noise that drives the error into saturation, plus a few clears
  task automatic run_random(int count);
    pos_item_t   it;
    int          kind;
    int unsigned spread;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      it.clear = (kind < 5);
      if (kind < 15) begin
        it.target_north = $urandom;
        it.target_east  = $urandom;
        it.target_down  = $urandom;
        it.pos_north    = $urandom;
        it.pos_east     = $urandom;
        it.pos_down     = $urandom;
      end else begin
        case ($urandom_range(0, 2))
          0:       spread = 1 << 12;
          1:       spread = 1 << 18;
          default: spread = 1 << 22;
        endcase
        it.target_north = $signed($urandom) >>> 1;
        it.target_east  = $signed($urandom) >>> 1;
        it.target_down  = $signed($urandom) >>> 1;
        it.pos_north    = it.target_north - rand_offset(spread);
        it.pos_east     = it.target_east - rand_offset(spread);
        it.pos_down     = it.target_down - rand_offset(spread);
      end
      pending_items.push_back(it);
    end
    wait_idle();
  endtask

  // Driver: predict on each accepted transfer, then present the next pending sample
  always @(posedge clk) begin : driver
    pos_item_t it;
    vel_cmd_t  want;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        want = predict_command(in_flight);
        expected_cmds.push_back(want);
        if (want.limited) n_limited++;
        if (in_flight.clear) n_clears++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_flight <= it;
          s_tdata   <= {it.pos_down, it.pos_east, it.pos_north,
                        it.target_down, it.target_east, it.target_north};
          s_tuser   <= it.clear;
          s_tvalid  <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transfer with the oldest expected command
  always @(posedge clk) begin : monitor
    vel_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("transfer with nothing expected", m_tdata[DATA_W-1:0], '0);
        end else begin
          want = expected_cmds.pop_front();
          if (m_tdata[DATA_W-1:0] !== want.vel_north)
            report_mismatch("vel_north", m_tdata[DATA_W-1:0], want.vel_north);
          if (m_tdata[2*DATA_W-1:DATA_W] !== want.vel_east)
            report_mismatch("vel_east", m_tdata[2*DATA_W-1:DATA_W], want.vel_east);
          if (m_tdata[3*DATA_W-1:2*DATA_W] !== want.vel_down)
            report_mismatch("vel_down", m_tdata[3*DATA_W-1:2*DATA_W], want.vel_down);
          if (m_tuser !== want.limited)
            report_mismatch("horiz_limited", m_tuser, want.limited);
        end
        n_results++;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands outstanding", cycle_count,
               expected_cmds.size());
      $display("FAIL position_pi_velocity_command");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_flight     = '0;
    n_errors      = 0;
    n_results     = 0;
    n_limited     = 0;
    n_clears      = 0;
    n_settings    = 0;
    cycle_count   = 0;
    send_idle_pct = 8;
    recv_idle_pct = 46;
    // Register values after reset
    horiz_kp_r    = 24'd65536;
    horiz_ki_r    = '0;
    horiz_lim_r   = 31'(ONE);
    vert_kp_r     = 24'd65536;
    vert_ki_r     = '0;
    vert_lim_r    = 31'(ONE);
    horiz_speed_r = 31'(10 * ONE);
    vert_speed_r  = 31'(ONE);
    for (int a = 0; a < 3; a++) axis_integ[a] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset gains: unity Kp, no integral, 10 m/s cap
    push_item(0, 0, 0, 0, 0, 0, 0);
    push_item(1, 3 * ONE, -2 * ONE, ONE, 0, 0, 0);
    push_item(0, ONE, 0, 0, 0, 0, 0);
    push_item(0, 0, -3 * ONE, 0, 0, 0, 0);
    push_item(0, 8 * ONE, 8 * ONE, 0, 0, 0, 0);            // vector over the cap
    push_item(0, 10 * ONE, 0, 0, 0, 0, 0);                 // exactly on the cap
    push_item(0, 10 * ONE + 1, 0, 0, 0, 0, 0);             // one step over it
    push_item(0, 0, 0, 5 * ONE, 0, 0, 0);                  // down clamp, positive
    push_item(0, 0, 0, -5 * ONE, 0, 0, 0);                 // down clamp, negative
    push_item(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_item(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_item(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
    push_item(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);
    push_item(0, 32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'sh5555_5555,
              32'sh5555_5555, 32'shFFFF_FFFF, 32'shAAAA_AAAA);
    push_item(1, 0, 0, 0, 0, 0, 0);
    // Wind the integrators up against their limits, then clear them
    apply_setting(ONE, 32'h1000_0000, 3 * ONE, 2 * ONE, 32'h0800_0000, ONE / 2,
                  10 * ONE, 4 * ONE);
    push_item(0, 2 * ONE, -ONE, ONE, 0, 0, 0);
    push_item(0, 2 * ONE, -ONE, ONE, 0, 0, 0);
    push_item(0, 2 * ONE, -ONE, ONE, 0, 0, 0);
    push_item(1, 2 * ONE, -ONE, ONE, 0, 0, 0);
    push_item(0, 0, 0, 0, 0, 0, 0);

    // Random part: five gain settings under each of three idle mixes
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 8;  recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      apply_setting(98304, 13421773, 2 * ONE, ONE, 26843546, ONE, 5 * ONE, 2 * ONE);
      run_random(60);
      apply_setting(3 * ONE, 32'h1000_0000, 100 * ONE, ONE / 2, 32'h2000_0000, 50 * ONE,
                    20 * ONE, 3 * ONE);
      run_random(60);
      apply_setting(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h00FF_FFFF,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      run_random(60);
      apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(60);
      apply_setting($urandom_range(0, 32'h00FF_FFFF), $urandom >> $urandom_range(0, 12),
                    $urandom >> $urandom_range(1, 31), $urandom_range(0, 32'h00FF_FFFF),
                    $urandom >> $urandom_range(0, 12), $urandom >> $urandom_range(1, 31),
                    $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000));
      run_random(60);
    end

    wait_idle();
    $display("checked %0d velocity commands over %0d gain settings and three idle mixes",
             n_results, n_settings);
    $display("%0d with the horizontal vector scaled, %0d clear requests, %0d mismatches",
             n_limited, n_clears, n_errors);
    if (n_errors == 0 && expected_cmds.size() == 0) begin
      $display("PASS position_pi_velocity_command");
    end else begin
      $display("FAIL position_pi_velocity_command");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pospi_pkg.sv
rtl/pospi_mul.sv
rtl/pospi_sqdiv.sv
rtl/position_pi_velocity_command.sv
bench/testbench.sv
